// File: design/fixed_block_free_list_allocator_unit_macros.svh
// Assertion macros shared by the pool allocator RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk_sig, rstn_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk_sig, rstn_sig, prop)

`define ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons)

`endif

`endif

// File: design/flba_pkg.sv
// Package of the pool allocator: request and status codes, controller states,
// and the command and status groups between controller and datapath. No dependencies.
package flba_pkg;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_POOL_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_FREE_REFUSED = 2'd2;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC
    } flba_state_t;

    typedef struct packed {
        logic init_wr;
        logic capture;
        logic commit;
    } flba_cmd_t;

    typedef struct packed {
        logic init_last;
        logic slot_free;
    } flba_stat_t;

endpackage

// File: design/flba_req_if.sv
// Request channel of the pool allocator: valid, ready and the request beat.
// No dependencies.
interface flba_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] free_index;

    modport source (output valid, output req_type, output free_index, input ready);
    modport sink (input valid, input req_type, input free_index, output ready);
endinterface

// File: design/flba_rsp_if.sv
// Response channel of the pool allocator: valid, ready and the result beat.
// No dependencies.
interface flba_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] block_index;
    logic [1:0] status;
    logic [8:0] live_count;

    modport source (output valid, output block_index, output status, output live_count,
                    input ready);
    modport sink (input valid, input block_index, input status, input live_count,
                  output ready);
endinterface

// File: design/fixed_block_free_list_allocator_unit.sv
// Top level of the fixed-block pool allocator with a LIFO free list.
// Depends on flba_pkg, flba_req_if, flba_rsp_if, flba_ctrl and flba_dp.
//
//   Channel  Direction  Beat contents
//   req      in         req_type, free_index
//   rsp      out        block_index, status, live_count
//
// Each request is accepted in ST_IDLE, where the link of the list head is read from the
// link memory into a register; ST_EXEC then commits the pop or push.
// After reset a clearing pass chains the link memory; req.ready stays low during it.
// A result waits in the output register while the next request is accepted; the
// commit stalls only while that register is full and not taken.
module fixed_block_free_list_allocator_unit #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    flba_req_if.sink   req,
    flba_rsp_if.source rsp
);
    import flba_pkg::*;

    flba_cmd_t  cmd;
    flba_stat_t stat;

    flba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    flba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req.req_type),
        .free_index  (req.free_index),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .block_index (rsp.block_index),
        .status      (rsp.status),
        .live_count  (rsp.live_count)
    );

endmodule

// File: design/flba_ctrl.sv
// Controller of the pool allocator: clearing pass, request capture and commit.
// Depends on flba_pkg.
module flba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  flba_pkg::flba_stat_t stat,
    output flba_pkg::flba_cmd_t  cmd
);
    import flba_pkg::*;

    flba_state_t state_reg;
    flba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd.init_wr = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (stat.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// File: design/flba_dp.sv
// Datapath of the pool allocator: link memory, head and count registers, result register.
// Depends on flba_pkg and the assertion macro header.
`include "fixed_block_free_list_allocator_unit_macros.svh"

module flba_dp #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  flba_pkg::flba_cmd_t  cmd,
    output flba_pkg::flba_stat_t stat,
    input  logic                 req_type,
    input  logic [7:0]           free_index,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [7:0]           block_index,
    output logic [1:0]           status,
    output logic [8:0]           live_count
);
    import flba_pkg::*;

    localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
    localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam logic [LINK_W-1:0]   N_LINK = LINK_W'(NUM_BLOCKS);
    localparam logic [LINK_W+7:0]   N_EXT  = (LINK_W + 8)'(NUM_BLOCKS);
    localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    logic [LINK_W-1:0] mem [NUM_BLOCKS];

    logic [LINK_W-1:0] head_reg;
    logic [LINK_W-1:0] head_next;
    logic [LINK_W-1:0] count_reg;
    logic [LINK_W-1:0] count_next;
    logic [IDX_W-1:0]  init_cnt_reg;
    logic [LINK_W-1:0] link_rd_reg;
    logic              req_type_reg;
    logic [7:0]        free_index_reg;
    logic              rsp_valid_reg;
    logic [7:0]        block_index_reg;
    logic [1:0]        status_reg;
    logic [8:0]        live_count_reg;

    logic [LINK_W+7:0] idx_ext;
    logic [LINK_W+7:0] blk_wide;
    logic [LINK_W+8:0] cnt_wide;
    logic              alloc_ok;
    logic              free_ok;
    logic [1:0]        status_next;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;

    assign idx_ext  = (LINK_W + 8)'(free_index_reg);
    assign alloc_ok = (req_type_reg == REQ_ALLOC) && (count_reg < N_LINK) && (head_reg < N_LINK);
    assign free_ok  = (req_type_reg == REQ_FREE) && (count_reg != '0) && (idx_ext < N_EXT);

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = STATUS_OK;
        if (req_type_reg == REQ_ALLOC)
        begin
            if (alloc_ok)
            begin
                head_next  = link_rd_reg;
                count_next = count_reg + 1'b1;
            end
            else
            begin
                status_next = STATUS_POOL_EMPTY;
            end
        end
        else
        begin
            if (free_ok)
            begin
                head_next  = idx_ext[LINK_W-1:0];
                count_next = count_reg - 1'b1;
            end
            else
            begin
                status_next = STATUS_FREE_REFUSED;
            end
        end
    end

    assign blk_wide = (LINK_W + 8)'(head_reg);
    assign cnt_wide = (LINK_W + 9)'(count_next);

    assign wr_en   = cmd.init_wr || (cmd.commit && free_ok);
    assign wr_addr = cmd.init_wr ? init_cnt_reg : idx_ext[IDX_W-1:0];
    assign wr_data = cmd.init_wr ? (LINK_W'(init_cnt_reg) + 1'b1) : head_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.capture)
        begin
            link_rd_reg <= mem[head_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            init_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_wr)
            begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                head_reg      <= head_next;
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg   <= req_type;
            free_index_reg <= free_index;
        end
        if (cmd.commit)
        begin
            block_index_reg <= alloc_ok ? blk_wide[7:0] : 8'd0;
            status_reg      <= status_next;
            live_count_reg  <= cnt_wide[8:0];
        end
    end

    assign stat.init_last = (init_cnt_reg == LAST_IDX);
    assign stat.slot_free = !rsp_valid_reg || rsp_ready;

    assign rsp_valid   = rsp_valid_reg;
    assign block_index = block_index_reg;
    assign status      = status_reg;
    assign live_count  = live_count_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= N_LINK)
    `ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, rsp_valid_reg)
    `ASSERT_NEXT(a_no_overwrite, clk, rst_n, rsp_valid_reg && !rsp_ready && !cmd.commit, $stable(status_reg) && $stable(live_count_reg))
    `ASSERT_NEXT(a_refused_keeps, clk, rst_n, cmd.commit && !alloc_ok && !free_ok, $stable(head_reg) && $stable(count_reg))

endmodule
